// ===== design/tewlf_pkg.sv =====
package tewlf_pkg;

  localparam int LINE_DEPTH       = 32768;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int TANH_TABLE_DEPTH = 1024;

  localparam int LINE_AW      = $clog2(LINE_DEPTH);
  localparam int SINE_AW      = $clog2(SINE_TABLE_DEPTH);
  localparam int TANH_AW      = $clog2(TANH_TABLE_DEPTH);
  localparam int TANH_ENTRIES = TANH_TABLE_DEPTH + 1;
  localparam int TANH_RAM_AW  = $clog2(TANH_ENTRIES);

  localparam logic signed [18:0] RESONANCE_Q16 = 19'sd183501;
  localparam logic signed [16:0] WET_Q15       = 17'sd22938;
  localparam logic [23:0]        Q22_ONE       = 24'h400000;
  localparam logic [27:0]        TANH_K27      = 28'd113246208;

  // Register map, word index on the configuration port
  localparam logic [2:0] REG_ENABLE   = 3'd0;
  localparam logic [2:0] REG_BASE     = 3'd1;
  localparam logic [2:0] REG_MIN      = 3'd2;
  localparam logic [2:0] REG_DEPTH    = 3'd3;
  localparam logic [2:0] REG_STEP     = 3'd4;
  localparam logic [2:0] REG_FEEDBACK = 3'd5;
  localparam logic [2:0] REG_COEFF    = 3'd6;
  localparam logic [2:0] REG_NORM     = 3'd7;

  typedef struct packed {
    logic [22:0] base_delay;
    logic [22:0] min_delay;
    logic [22:0] lfo_depth;
    logic [31:0] lfo_step;
    logic [14:0] feedback_gain;
    logic [19:0] ladder_coeff;
    logic [16:0] ladder_norm;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic               pass;
    logic signed [15:0] sample;
  } q_head_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } back_ctl_t;

endpackage

// ===== design/tewlf_ram.sv =====
module tewlf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== design/tewlf_front.sv =====
module tewlf_front
  import tewlf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               effect_enable,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_sample_in,
  output q_head_t            head,
  input  back_ctl_t          ctl
);

  logic               pass_r   [2];
  logic signed [15:0] sample_r [2];
  logic               wptr_r, wptr_nxt;
  logic               rptr_r, rptr_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic               push, pop;

  assign in_stall = ctl.busy || (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign pop      = ctl.pop && (cnt_r != 2'd0);

  assign head.valid  = (cnt_r != 2'd0);
  assign head.pass   = pass_r[rptr_r];
  assign head.sample = sample_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // The enable is sampled as the item enters, so a disabled item is tagged to pass through.
  always_ff @(posedge clk) begin
    if (push) begin
      pass_r[wptr_r]   <= !effect_enable;
      sample_r[wptr_r] <= in_sample_in;
    end
  end

endmodule

// ===== design/tewlf_back.sv =====
module tewlf_back
  import tewlf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  q_head_t            head,
  output back_ctl_t          ctl,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample_out
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_SIN0 = 5'd1;
  localparam logic [4:0] S_SIN1 = 5'd2;
  localparam logic [4:0] S_SIN2 = 5'd3;
  localparam logic [4:0] S_SIN3 = 5'd4;
  localparam logic [4:0] S_DLY0 = 5'd5;
  localparam logic [4:0] S_DLY1 = 5'd6;
  localparam logic [4:0] S_RDA  = 5'd7;
  localparam logic [4:0] S_RDB  = 5'd8;
  localparam logic [4:0] S_RDW  = 5'd9;
  localparam logic [4:0] S_INT0 = 5'd10;
  localparam logic [4:0] S_INT1 = 5'd11;
  localparam logic [4:0] S_L0   = 5'd12;
  localparam logic [4:0] S_L1   = 5'd13;
  localparam logic [4:0] S_L2   = 5'd14;
  localparam logic [4:0] S_G    = 5'd15;
  localparam logic [4:0] S_A    = 5'd16;
  localparam logic [4:0] S_T0   = 5'd17;
  localparam logic [4:0] S_T1   = 5'd18;
  localparam logic [4:0] S_T2   = 5'd19;
  localparam logic [4:0] S_T3   = 5'd20;
  localparam logic [4:0] S_T4   = 5'd21;
  localparam logic [4:0] S_T5   = 5'd22;
  localparam logic [4:0] S_W0   = 5'd23;
  localparam logic [4:0] S_W1   = 5'd24;
  localparam logic [4:0] S_W2   = 5'd25;
  localparam logic [4:0] S_OUT  = 5'd26;

  localparam logic [1:0] F_X2  = 2'd0;
  localparam logic [1:0] F_ND  = 2'd1;
  localparam logic [1:0] F_DIV = 2'd2;
  localparam logic [1:0] F_WR  = 2'd3;

  localparam int ZSH = 17 - SINE_AW;
  localparam int XSH = 24 - TANH_AW;

  // ---------------- control registers ----------------
  logic [4:0]             state_r, state_nxt;
  logic [1:0]             k_r, k_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   clr_busy_r, clr_busy_nxt;
  logic [LINE_AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic                   fill_busy_r, fill_busy_nxt;
  logic [TANH_RAM_AW-1:0] fill_idx_r, fill_idx_nxt;
  logic [1:0]             fstate_r, fstate_nxt;
  logic [LINE_AW-1:0]     wp_r, wp_nxt;
  logic [31:0]            phase_r, phase_nxt;
  logic signed [23:0]     y_r [4];

  // ---------------- payload registers ----------------
  logic signed [15:0]     x_r;
  logic [16:0]            z2_r;
  logic [15:0]            t_r;
  logic signed [15:0]     sine_r;
  logic signed [24:0]     sdp_r;
  logic [LINE_AW+7:0]     rp_r;
  logic signed [23:0]     a_r, b_r;
  logic signed [33:0]     dprod_r;
  logic signed [23:0]     delayed_r;
  logic signed [42:0]     rprod_r;
  logic signed [27:0]     diff_r;
  logic signed [29:0]     acc_r;
  logic signed [28:0]     gy_r;
  logic [TANH_AW-1:0]     tidx_r;
  logic [23:0]            tfr_r;
  logic                   neg_r, sat_r;
  logic signed [23:0]     e0_r, e1_r;
  logic signed [49:0]     tprod_r;
  logic signed [22:0]     fb_r;
  logic signed [24:0]     wet_r;
  logic signed [15:0]     res_r;
  logic signed [15:0]     out_r;
  logic [25:0]            x2_r;
  logic [52:0]            rem_r;
  logic [28:0]            den_r;
  logic [4:0]             fk_r;
  logic [23:0]            fq_r;

  // ---------------- memories ----------------
  logic                   dram_we;
  logic [LINE_AW-1:0]     dram_addr;
  logic [23:0]            dram_wdata, dram_rdata;
  logic                   tram_we;
  logic [TANH_RAM_AW-1:0] tram_addr;
  logic [23:0]            tram_rdata;

  tewlf_ram #(.WIDTH(24), .DEPTH(LINE_DEPTH)) u_line (
    .clk   (clk),
    .we    (dram_we),
    .addr  (dram_addr),
    .wdata (dram_wdata),
    .rdata (dram_rdata)
  );

  tewlf_ram #(.WIDTH(24), .DEPTH(TANH_ENTRIES)) u_tanh (
    .clk   (clk),
    .we    (tram_we),
    .addr  (tram_addr),
    .wdata (fq_r),
    .rdata (tram_rdata)
  );

  // ---------------- combinational datapath ----------------
  logic [SINE_AW-1:0]     sidx;
  logic [1:0]             quad;
  logic [14:0]            zq;
  logic [15:0]            z16;
  logic [31:0]            zz_prod;
  logic [32:0]            z2c_prod;
  logic [32:0]            tz_prod;
  logic [31:0]            zt_prod;
  logic [16:0]            s_mag;
  logic signed [39:0]     sdp_prod;
  logic signed [25:0]     dly, minv, dclamp;
  logic [LINE_AW-1:0]     ri;
  logic signed [24:0]     ddiff;
  logic signed [33:0]     dprod;
  logic signed [42:0]     rprod;
  logic signed [45:0]     uprod;
  logic signed [44:0]     gprod;
  logic signed [30:0]     arg;
  logic [30:0]            mag;
  logic signed [24:0]     tdiff;
  logic signed [49:0]     tprod;
  logic signed [23:0]     tres, ynew;
  logic signed [39:0]     fprod;
  logic signed [39:0]     wprod;
  logic signed [25:0]     wr;
  logic signed [23:0]     wr_sat;
  logic signed [26:0]     mix, yv;
  logic signed [15:0]     y_sat;
  logic [24:0]            fx;
  logic [47:0]            fxx_prod;
  logic [52:0]            fnum_prod;
  logic [52:0]            dsh;

  assign sidx = phase_r[31 -: SINE_AW];
  assign quad = sidx[SINE_AW-1 -: 2];
  assign zq   = {sidx[SINE_AW-3:0], {ZSH{1'b0}}};
  // Odd quadrants run the quarter wave backwards.
  assign z16  = quad[0] ? 16'(17'd32768 - 17'(zq)) : 16'(zq);

  assign zz_prod  = z16 * z16;
  assign z2c_prod = 33'(z2_r) * 33'd2320;
  assign tz_prod  = 33'(t_r) * 33'(z2_r);
  assign zt_prod  = z16 * t_r;
  assign s_mag    = 17'(zt_prod >> 15);

  assign sdp_prod = sine_r * $signed({1'b0, cfg.lfo_depth});
  assign dly      = $signed({3'b000, cfg.base_delay}) + 26'(sdp_r);
  assign minv     = $signed({3'b000, cfg.min_delay});
  assign dclamp   = (dly < minv) ? minv : dly;
  assign ri       = rp_r[LINE_AW+7:8];

  assign ddiff = 25'(b_r) - 25'(a_r);
  assign dprod = ddiff * $signed({1'b0, rp_r[7:0]});

  assign rprod = RESONANCE_Q16 * y_r[3];
  assign uprod = diff_r * $signed({1'b0, cfg.ladder_norm});
  assign gprod = $signed({1'b0, cfg.ladder_coeff}) * y_r[k_r];
  assign arg   = 31'(acc_r) + 31'(gy_r);
  assign mag   = arg[30] ? 31'(-arg) : 31'(arg);

  assign tdiff = 25'(e1_r) - 25'(e0_r);
  assign tprod = tdiff * $signed({1'b0, tfr_r});
  assign tres  = sat_r ? $signed(Q22_ONE) : 24'(e0_r + 24'(tprod_r >>> 24));
  assign ynew  = neg_r ? -tres : tres;

  assign fprod = y_r[3] * $signed({1'b0, cfg.feedback_gain});
  assign wprod = delayed_r * WET_Q15;
  assign wr    = (26'(x_r) <<< 5) + 26'(fb_r);

  always_comb begin
    if (wr > 26'sd8388607) begin
      wr_sat = 24'sh7FFFFF;
    end else if (wr < -26'sd8388608) begin
      wr_sat = 24'sh800000;
    end else begin
      wr_sat = 24'(wr);
    end
  end

  assign mix = (27'(x_r) <<< 5) + 27'(wet_r);
  assign yv  = (mix + 27'sd16) >>> 5;

  always_comb begin
    if (yv > 27'sd32767) begin
      y_sat = 16'sh7FFF;
    end else if (yv < -27'sd32768) begin
      y_sat = 16'sh8000;
    end else begin
      y_sat = 16'(yv);
    end
  end

  // Tanh table fill: x = i*4/DEPTH in Q22, value x(27+x^2)/(27+9x^2) by restoring division.
  assign fx        = {fill_idx_r, {XSH{1'b0}}};
  assign fxx_prod  = 48'(fx) * 48'(fx);
  assign fnum_prod = 53'(fx) * 53'(TANH_K27 + 28'(x2_r));
  assign dsh       = 53'(den_r) << fk_r;

  // ---------------- memory ports ----------------
  always_comb begin
    dram_we    = 1'b0;
    dram_wdata = 24'(wr_sat);
    dram_addr  = ri;
    if (clr_busy_r) begin
      dram_we    = 1'b1;
      dram_wdata = '0;
      dram_addr  = clr_cnt_r;
    end else if (state_r == S_W1) begin
      dram_we   = 1'b1;
      dram_addr = wp_r;
    end else if (state_r == S_RDB) begin
      dram_addr = ri + LINE_AW'(1);
    end
  end

  always_comb begin
    tram_we   = fill_busy_r && (fstate_r == F_WR);
    tram_addr = TANH_RAM_AW'(tidx_r);
    if (fill_busy_r) begin
      tram_addr = fill_idx_r;
    end else if (state_r == S_T2) begin
      tram_addr = TANH_RAM_AW'(tidx_r) + TANH_RAM_AW'(1);
    end
  end

  assign ctl.busy = clr_busy_r || fill_busy_r;
  assign ctl.pop  = (state_r == S_IDLE) && !ctl.busy && head.valid;

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_r;

  // ---------------- clearing pass and tanh table fill ----------------
  always_comb begin
    clr_busy_nxt  = clr_busy_r;
    clr_cnt_nxt   = clr_cnt_r;
    fill_busy_nxt = fill_busy_r;
    fill_idx_nxt  = fill_idx_r;
    fstate_nxt    = fstate_r;
    if (clr_busy_r) begin
      clr_cnt_nxt = clr_cnt_r + LINE_AW'(1);
      if (clr_cnt_r == LINE_AW'(LINE_DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
    if (fill_busy_r) begin
      unique case (fstate_r)
        F_X2: begin
          fstate_nxt = (fx >= 25'd12582912) ? F_WR : F_ND;
        end
        F_ND: begin
          fstate_nxt = F_DIV;
        end
        F_DIV: begin
          if (fk_r == 5'd0) begin
            fstate_nxt = F_WR;
          end
        end
        F_WR: begin
          fstate_nxt = F_X2;
          if (fill_idx_r == TANH_RAM_AW'(TANH_TABLE_DEPTH)) begin
            fill_busy_nxt = 1'b0;
          end else begin
            fill_idx_nxt = fill_idx_r + TANH_RAM_AW'(1);
          end
        end
        default: fstate_nxt = F_X2;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fill_busy_r) begin
      unique case (fstate_r)
        F_X2: begin
          x2_r <= 26'(fxx_prod >> 22);
          fq_r <= Q22_ONE;
        end
        F_ND: begin
          rem_r <= fnum_prod;
          den_r <= 29'(TANH_K27) + 29'(x2_r) * 29'd9;
          fk_r  <= 5'd23;
          fq_r  <= '0;
        end
        F_DIV: begin
          if (rem_r >= dsh) begin
            rem_r     <= rem_r - dsh;
            fq_r[fk_r] <= 1'b1;
          end
          fk_r <= fk_r - 5'd1;
        end
        default: ;
      endcase
    end
  end

  // ---------------- item sequencer ----------------
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    wp_nxt        = wp_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (ctl.pop) begin
          if (head.pass) begin
            state_nxt = S_OUT;
          end else begin
            phase_nxt = phase_r + cfg.lfo_step;
            state_nxt = S_SIN0;
          end
        end
      end
      S_SIN0: state_nxt = S_SIN1;
      S_SIN1: state_nxt = S_SIN2;
      S_SIN2: state_nxt = S_SIN3;
      S_SIN3: state_nxt = S_DLY0;
      S_DLY0: state_nxt = S_DLY1;
      S_DLY1: state_nxt = S_RDA;
      S_RDA:  state_nxt = S_RDB;
      S_RDB:  state_nxt = S_RDW;
      S_RDW:  state_nxt = S_INT0;
      S_INT0: state_nxt = S_INT1;
      S_INT1: state_nxt = S_L0;
      S_L0:   state_nxt = S_L1;
      S_L1:   state_nxt = S_L2;
      S_L2: begin
        k_nxt     = 2'd0;
        state_nxt = S_G;
      end
      S_G:    state_nxt = S_A;
      S_A:    state_nxt = (|mag[30:24]) ? S_T5 : S_T0;
      S_T0:   state_nxt = S_T1;
      S_T1:   state_nxt = S_T2;
      S_T2:   state_nxt = S_T3;
      S_T3:   state_nxt = S_T4;
      S_T4:   state_nxt = S_T5;
      S_T5: begin
        k_nxt     = k_r + 2'd1;
        state_nxt = (k_r == 2'd3) ? S_W0 : S_G;
      end
      S_W0:   state_nxt = S_W1;
      S_W1: begin
        wp_nxt    = wp_r + LINE_AW'(1);
        state_nxt = S_W2;
      end
      S_W2:   state_nxt = S_OUT;
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // A saturated ladder argument skips the table read; S_T5 then takes full scale from the flag.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        x_r   <= head.sample;
        res_r <= head.sample;
      end
      S_SIN0: z2_r <= 17'(zz_prod >> 15);
      S_SIN1: t_r  <= 16'(17'd21024 - 17'(z2c_prod >> 15));
      S_SIN2: t_r  <= 16'(17'd51472 - 17'(tz_prod >> 15));
      S_SIN3: begin
        if (s_mag > 17'd32767) begin
          sine_r <= quad[1] ? -16'sd32767 : 16'sd32767;
        end else begin
          sine_r <= quad[1] ? -$signed(16'(s_mag)) : $signed(16'(s_mag));
        end
      end
      S_DLY0: sdp_r <= 25'(sdp_prod >>> 15);
      S_DLY1: rp_r  <= {wp_r, 8'b0} - dclamp[LINE_AW+7:0];
      S_RDB:  a_r   <= $signed(dram_rdata);
      S_RDW:  b_r   <= $signed(dram_rdata);
      S_INT0: dprod_r   <= dprod;
      S_INT1: delayed_r <= 24'(a_r + 24'(dprod_r >>> 8));
      S_L0:   rprod_r   <= rprod;
      S_L1:   diff_r    <= (28'(delayed_r) <<< 2) - 28'(rprod_r >>> 16);
      S_L2:   acc_r     <= 30'(uprod >>> 16);
      S_G: begin
        gy_r  <= 29'(gprod >>> 16);
        sat_r <= 1'b0;
      end
      S_A: begin
        neg_r  <= arg[30];
        sat_r  <= |mag[30:24];
        tidx_r <= mag[23 -: TANH_AW];
        tfr_r  <= {mag[23-TANH_AW:0], {TANH_AW{1'b0}}};
      end
      S_T2: e0_r    <= $signed(tram_rdata);
      S_T3: e1_r    <= $signed(tram_rdata);
      S_T4: tprod_r <= tprod;
      S_T5: acc_r   <= 30'(ynew);
      S_W0: fb_r    <= 23'(fprod >>> 17);
      S_W1: wet_r   <= 25'(wprod >>> 15);
      S_W2: res_r   <= y_sat;
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_r <= res_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= 2'd0;
      out_valid_r <= 1'b0;
      clr_busy_r  <= 1'b1;
      clr_cnt_r   <= '0;
      fill_busy_r <= 1'b1;
      fill_idx_r  <= '0;
      fstate_r    <= F_X2;
      wp_r        <= '0;
      phase_r     <= '0;
      for (int i = 0; i < 4; i++) begin
        y_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      clr_busy_r  <= clr_busy_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      fill_busy_r <= fill_busy_nxt;
      fill_idx_r  <= fill_idx_nxt;
      fstate_r    <= fstate_nxt;
      wp_r        <= wp_nxt;
      phase_r     <= phase_nxt;
      if (state_r == S_T5) begin
        y_r[k_r] <= ynew;
      end
    end
  end

endmodule

// ===== design/tape_echo_with_ladder_feedback_core.sv =====
// Channel    Direction  Handshake                Payload
// in         sink       in_valid / in_stall      in_sample_in   (signed Q15)
// out        source     out_valid / out_stall    out_sample_out (signed Q15)
// cfg        APB slave  psel, penable, pready    paddr, pwdata, prdata
//
// An enabled sample runs the full back-end sequence, which is shorter for each ladder
// stage whose argument saturates; a bypassed sample goes straight to output. The
// single-port delay line RAM and the shared multiplier steps of the four ladder
// stages set that. After reset a clearing pass zeroes the delay line with in_stall
// high; the tanh table is built alongside it.
// A two-entry queue takes samples while a finished transfer waits on out_stall.
module tape_echo_with_ladder_feedback_core
  import tewlf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_sample_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic      enable_r;
  cfg_t      cfg_r;
  q_head_t   head;
  back_ctl_t ctl;
  logic      wr_en;
  logic [2:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r            <= 1'b1;
      cfg_r.base_delay    <= 23'd3686400;
      cfg_r.min_delay     <= 23'd245760;
      cfg_r.lfo_depth     <= 23'd24576;
      cfg_r.lfo_step      <= 32'd44739;
      cfg_r.feedback_gain <= 15'd16384;
      cfg_r.ladder_coeff  <= 20'd13036;
      cfg_r.ladder_norm   <= 17'd52515;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_ENABLE:   enable_r            <= pwdata[0];
        REG_BASE:     cfg_r.base_delay    <= pwdata[22:0];
        REG_MIN:      cfg_r.min_delay     <= pwdata[22:0];
        REG_DEPTH:    cfg_r.lfo_depth     <= pwdata[22:0];
        REG_STEP:     cfg_r.lfo_step      <= pwdata;
        REG_FEEDBACK: cfg_r.feedback_gain <= pwdata[14:0];
        REG_COEFF:    cfg_r.ladder_coeff  <= pwdata[19:0];
        REG_NORM:     cfg_r.ladder_norm   <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ENABLE:   prdata = {31'b0, enable_r};
      REG_BASE:     prdata = {9'b0, cfg_r.base_delay};
      REG_MIN:      prdata = {9'b0, cfg_r.min_delay};
      REG_DEPTH:    prdata = {9'b0, cfg_r.lfo_depth};
      REG_STEP:     prdata = cfg_r.lfo_step;
      REG_FEEDBACK: prdata = {17'b0, cfg_r.feedback_gain};
      REG_COEFF:    prdata = {12'b0, cfg_r.ladder_coeff};
      REG_NORM:     prdata = {15'b0, cfg_r.ladder_norm};
      default:      prdata = '0;
    endcase
  end

  tewlf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .effect_enable (enable_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample_in  (in_sample_in),
    .head          (head),
    .ctl           (ctl)
  );

  tewlf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .head           (head),
    .ctl            (ctl),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out)
  );

endmodule

// ===== tb/sv/echo_checker.sv =====
module echo_checker
  import tewlf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] in_sample_in,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_sample_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE_Q22 = 64'sd4194304;
  localparam longint SPAN    = longint'(LINE_DEPTH) * 256;

  // Shadow configuration
  logic        echo_on;
  logic [22:0] base_dly, min_dly, swing;
  logic [31:0] phase_inc;
  logic [14:0] fb_gain;
  logic [19:0] coeff;
  logic [16:0] norm;

  // Shadow state
  longint line_mem [LINE_DEPTH];
  int unsigned wr_pos;
  logic [31:0] phase;
  longint st1, st2, st3, st4;
  longint tanh_tab [TANH_TABLE_DEPTH + 2];

  logic signed [15:0] expected_q [$];

  initial begin
    longint x, x2;
    errors = 0;
    pending = 0;
    for (int i = 0; i <= TANH_TABLE_DEPTH + 1; i++) begin
      x = (longint'(i) << 24) / TANH_TABLE_DEPTH;
      if (x >= 3 * ONE_Q22) begin
        tanh_tab[i] = ONE_Q22;
      end else begin
        x2 = (x * x) >>> 22;
        tanh_tab[i] = (x * (27 * ONE_Q22 + x2)) / (27 * ONE_Q22 + 9 * x2);
      end
    end
  end

  function automatic longint quarter_sine(longint z);
    longint z2, t;
    z2 = (z * z) >>> 15;
    t = 21024 - ((2320 * z2) >>> 15);
    t = 51472 - ((t * z2) >>> 15);
    t = (z * t) >>> 15;
    return (t > 32767) ? 32767 : t;
  endfunction

  function automatic longint lfo_value(logic [31:0] ph);
    longint idx, z, s;
    idx = longint'(ph >> 22);
    z = ((idx * 4) % SINE_TABLE_DEPTH) * 32768 / SINE_TABLE_DEPTH;
    if (idx[8]) z = 32768 - z;
    s = quarter_sine(z);
    return idx[9] ? -s : s;
  endfunction

  function automatic longint soft_clip(longint a);
    longint m, r, p, fr, e0, e1;
    m = (a < 0) ? -a : a;
    if (m >= 4 * ONE_Q22) begin
      r = ONE_Q22;
    end else begin
      p = m * TANH_TABLE_DEPTH;
      fr = p & 64'hFFFFFF;
      e0 = tanh_tab[p >> 24];
      e1 = tanh_tab[(p >> 24) + 1];
      r = e0 + (((e1 - e0) * fr) >>> 24);
    end
    return (a < 0) ? -r : r;
  endfunction

  function automatic logic signed [15:0] echo_predict(logic signed [15:0] s);
    longint x, dly, rp, ri, rn, fr, a, b, delayed, g, u, wr, mix, y;
    x = longint'(s);
    if (!echo_on) return s;
    phase = phase + phase_inc;
    dly = longint'(base_dly) + ((lfo_value(phase) * longint'(swing)) >>> 15);
    if (dly < longint'(min_dly)) dly = longint'(min_dly);
    rp = longint'(wr_pos) * 256 + SPAN - (dly % SPAN);
    if (rp >= SPAN) rp -= SPAN;
    ri = rp >> 8;
    rn = (ri + 1) % LINE_DEPTH;
    fr = rp & 255;
    a = line_mem[ri];
    b = line_mem[rn];
    delayed = a + (((b - a) * fr) >>> 8);
    g = longint'(coeff);
    u = ((delayed * 4 - ((longint'(RESONANCE_Q16) * st4) >>> 16)) * longint'(norm)) >>> 16;
    st1 = soft_clip(u + ((g * st1) >>> 16));
    st2 = soft_clip(st1 + ((g * st2) >>> 16));
    st3 = soft_clip(st2 + ((g * st3) >>> 16));
    st4 = soft_clip(st3 + ((g * st4) >>> 16));
    wr = x * 32 + ((st4 * longint'(fb_gain)) >>> 17);
    if (wr > 64'sd8388607) wr = 64'sd8388607;
    if (wr < -64'sd8388608) wr = -64'sd8388608;
    line_mem[wr_pos] = wr;
    wr_pos = (wr_pos + 1) % LINE_DEPTH;
    mix = x * 32 + ((delayed * longint'(WET_Q15)) >>> 15);
    y = (mix + 16) >>> 5;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    return 16'(y);
  endfunction

  always @(posedge clk) begin
    logic signed [15:0] want;
    if (!rst_n) begin
      echo_on   = 1'b1;
      base_dly  = 23'd3686400;
      min_dly   = 23'd245760;
      swing     = 23'd24576;
      phase_inc = 32'd44739;
      fb_gain   = 15'd16384;
      coeff     = 20'd13036;
      norm      = 17'd52515;
      for (int i = 0; i < LINE_DEPTH; i++) line_mem[i] = 0;
      wr_pos = 0;
      phase = '0;
      st1 = 0; st2 = 0; st3 = 0; st4 = 0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_ENABLE:   echo_on   = pwdata[0];
          REG_BASE:     base_dly  = pwdata[22:0];
          REG_MIN:      min_dly   = pwdata[22:0];
          REG_DEPTH:    swing     = pwdata[22:0];
          REG_STEP:     phase_inc = pwdata;
          REG_FEEDBACK: fb_gain   = pwdata[14:0];
          REG_COEFF:    coeff     = pwdata[19:0];
          REG_NORM:     norm      = pwdata[16:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("sample_out: unexpected transfer, actual %0d", out_sample_out);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (want !== out_sample_out) begin
            $error("sample_out: expected %0d, actual %0d", want, out_sample_out);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) expected_q.push_back(echo_predict(in_sample_in));
    end
    pending = expected_q.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  import tewlf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1500000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] in_sample_in;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] out_sample_out;
  logic               psel, penable, pwrite, pready;
  logic [4:0]         paddr;
  logic [31:0]        pwdata, prdata;
  int                 errors, pending;
  int                 cycles;
  int                 burst_left;
  int                 stall_mode, stall_left;

  tape_echo_with_ladder_feedback_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample_in(in_sample_in),
    .out_valid(out_valid), .out_stall(out_stall), .out_sample_out(out_sample_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  echo_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample_in(in_sample_in),
    .out_valid(out_valid), .out_stall(out_stall), .out_sample_out(out_sample_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver stalls in modes: free running, light random, heavy random, long holds.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 2);
      2: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= (stall_left % 64) < 40;
    endcase
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Hold the sender off until every expected transfer has come, then let the
  // back end settle before any register is touched.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic send(logic signed [15:0] s);
    in_valid     <= 1'b1;
    in_sample_in <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 70)) @(posedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  task automatic idle_sender();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 63)) - 16'sd32;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic setup(logic en, logic [22:0] b, logic [22:0] m, logic [22:0] d,
                       logic [31:0] st, logic [14:0] fb, logic [19:0] c, logic [16:0] n);
    reg_write(REG_ENABLE, {31'd0, en});
    reg_write(REG_BASE, {9'd0, b});
    reg_write(REG_MIN, {9'd0, m});
    reg_write(REG_DEPTH, {9'd0, d});
    reg_write(REG_STEP, st);
    reg_write(REG_FEEDBACK, {17'd0, fb});
    reg_write(REG_COEFF, {12'd0, c});
    reg_write(REG_NORM, {15'd0, n});
  endtask

  initial begin
    logic signed [15:0] directed [10];
    directed = '{16'sh7FFF, 16'sh8000, 16'sd0, -16'sd1, 16'sd1,
                 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh5555, 16'shAAAA};
    cycles = 0;
    burst_left = 0;
    stall_mode = 0;
    stall_left = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_in = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings with extremes of the sample.
    foreach (directed[i]) send(directed[i]);
    drain();
    // Bypass.
    reg_write(REG_ENABLE, 32'd0);
    foreach (directed[i]) send(directed[i]);
    drain();
    // Short exact delay, heavy feedback and an over-range ladder: saturation.
    setup(1'b1, 23'd768, 23'd0, 23'd0, 32'd0, 15'h7FFF, 20'hFFFFF, 17'h1FFFF);
    for (int i = 0; i < 12; i++) send(i[0] ? 16'sh7FFF : 16'sh8000);
    drain();
    // Zero delay reads the oldest word at the write position.
    setup(1'b1, 23'd0, 23'd0, 23'd0, 32'd0, 15'd16384, 20'd13036, 17'd65536);
    for (int i = 0; i < 6; i++) send(rand_sample());
    drain();
    // Delay from just under the line length upward, full swing and an all-ones step: wrap-around.
    setup(1'b1, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 32'hFFFFFFFF, 15'd0, 20'd0, 17'd0);
    for (int i = 0; i < 6; i++) send(rand_sample());
    drain();
    reg_write(REG_MIN, 32'd0);
    for (int i = 0; i < 6; i++) send(rand_sample());
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      setup(($urandom_range(0, 7) != 0),
            ($urandom_range(0, 3) == 0) ? 23'($urandom) : 23'($urandom_range(0, 256 * 300)),
            ($urandom_range(0, 2) == 0) ? 23'($urandom_range(0, 256 * 400)) : 23'd0,
            ($urandom_range(0, 3) == 0) ? 23'($urandom) : 23'($urandom_range(0, 256 * 100)),
            ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 1 << 24),
            15'($urandom),
            ($urandom_range(0, 4) == 0) ? 20'($urandom) : 20'($urandom_range(0, 655360)),
            ($urandom_range(0, 4) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536)));
      for (int i = 0; i < 118; i++) send(rand_sample());
      idle_sender();
      drain();
    end

    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/tewlf_pkg.sv
design/tewlf_ram.sv
design/tewlf_front.sv
design/tewlf_back.sv
design/tape_echo_with_ladder_feedback_core.sv
tb/sv/echo_checker.sv
tb/sv/tb_top.sv
